// ===== hw/rtl/gcp_pkg.sv =====
`timescale 1ns / 1ps

package gcp_pkg;

  // Largest number of agents the value memory is sized for.
  localparam int MAX_AGENTS = 8;
  localparam int MASK_W     = MAX_AGENTS;
  localparam int DEPTH      = 1 << MAX_AGENTS;
  localparam int VALUE_W    = 32;
  localparam int CNT_W      = 4;

  localparam logic signed [VALUE_W-1:0] VALUE_FLOOR = -32'sd1000000;
  localparam logic [CNT_W-1:0]          COUNT_RESET = CNT_W'(MAX_AGENTS);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_PICK = 1'b1;

  // Agent count clamped to what the memory holds.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
    return (n > CNT_W'(MAX_AGENTS)) ? CNT_W'(MAX_AGENTS) : n;
  endfunction

  // Mask with the low n bits set.
  function automatic logic [MASK_W-1:0] full_mask(input logic [CNT_W-1:0] n);
    logic [MASK_W:0] t;
    t = (MASK_W+1)'(1) << n;
    return MASK_W'(t - (MASK_W+1)'(1));
  endfunction

  // Enumeration position to agent mask: agent 0 sits at the top bit of n bits.
  function automatic logic [MASK_W-1:0] position_to_mask(input logic [MASK_W-1:0] p,
                                                         input logic [CNT_W-1:0]  n);
    logic [MASK_W-1:0] r;
    for (int k = 0; k < MASK_W; k++) begin
      r[k] = p[MASK_W-1-k];
    end
    return r >> (CNT_W'(MAX_AGENTS) - n);
  endfunction

endpackage

// ===== hw/rtl/gcp_if.sv =====
`timescale 1ns / 1ps

interface gcp_item_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [gcp_pkg::MASK_W-1:0]         coalition_index;
  logic signed [gcp_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output coalition_index, output value,
                  input ready);
  modport sink (input valid, input op, input coalition_index, input value,
                output ready);
endinterface

interface gcp_result_if;
  logic                       valid;
  logic                       ready;
  logic [gcp_pkg::MASK_W-1:0] coalition_mask;
  logic                       is_last;
  logic                       status;

  modport source (output valid, output coalition_mask, output is_last, output status,
                  input ready);
  modport sink (input valid, input coalition_mask, input is_last, input status,
                output ready);
endinterface

interface gcp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [gcp_pkg::CNT_W-1:0] agent_count;

  modport source (output valid, output agent_count, input ready);
  modport sink (input valid, input agent_count, output ready);
endinterface

// ===== hw/rtl/greedy_coalition_packing.sv =====
`timescale 1ns / 1ps
// A load request is written to the value memory and gives no result.
// A solve request runs one scan per pick over every nonempty subset of the n agents, read
// one after another through the single read port of the value memory, then posts the pick
// once the output register is free: up to n picks in all. One request at a time.
// Reset clears all control state and sets agent_count to 8; the value memory is not cleared.
module greedy_coalition_packing (
  input  logic          clk,
  input  logic          rst,
  gcp_item_if.sink      item,
  gcp_result_if.source  result,
  gcp_cfg_if.sink       cfg
);

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  // Configuration register.
  logic [gcp_pkg::CNT_W-1:0] agent_count;

  // Value memory: one write port used by loads, one read port used by scans.
  // Loads happen only while idle; the read port reads every cycle, but its data
  // is used only while scanning, so a load never changes a value a scan compares.
  logic signed [gcp_pkg::VALUE_W-1:0] value_store [gcp_pkg::DEPTH];
  logic signed [gcp_pkg::VALUE_W-1:0] rd_data;

  // Scan state.
  logic [gcp_pkg::MASK_W-1:0]         used_agents;
  logic [gcp_pkg::MASK_W-1:0]         scan_position;
  logic                               issuing;
  logic                               pipe_valid;
  logic [gcp_pkg::MASK_W-1:0]         pipe_mask;
  logic signed [gcp_pkg::VALUE_W-1:0] best_value;
  logic [gcp_pkg::MASK_W-1:0]         best_subset;
  logic                               found;

  // Output register.
  logic                       res_valid;
  logic [gcp_pkg::MASK_W-1:0] res_mask;
  logic                       res_last;
  logic                       res_status;

  logic [gcp_pkg::CNT_W-1:0]  n_eff;
  logic [gcp_pkg::MASK_W-1:0] full;
  logic [gcp_pkg::MASK_W-1:0] scan_mask;
  logic                       eligible;
  logic                       item_acc;
  logic                       cfg_acc;
  logic                       out_free;
  logic                       res_load;
  logic                       better;
  logic [gcp_pkg::MASK_W-1:0] used_after;
  logic                       last_pick;

  assign n_eff     = gcp_pkg::clamp_count(agent_count);
  assign full      = gcp_pkg::full_mask(n_eff);
  assign scan_mask = gcp_pkg::position_to_mask(scan_position, n_eff);
  assign eligible  = (scan_mask & used_agents) == '0;

  assign item.ready = (state == ST_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign cfg.ready  = 1'b1;
  assign cfg_acc    = cfg.valid && cfg.ready;

  // The output register is free when empty or when its request leaves this cycle.
  assign out_free = !res_valid || result.ready;

  // A pick is posted into the output register in this cycle.
  assign res_load = (state == ST_DONE) && out_free;

  // Strictly greater wins, so the earliest subset in enumeration order keeps a tie.
  assign better = pipe_valid && (rd_data > best_value);

  // A run ends when every agent is covered or when no subset beats the floor.
  assign used_after = used_agents | best_subset;
  assign last_pick  = !found || (used_after == full);

  assign result.valid          = res_valid;
  assign result.coalition_mask = res_mask;
  assign result.is_last        = res_last;
  assign result.status         = res_status;

  always_ff @(posedge clk) begin
    if (item_acc && (item.op == gcp_pkg::OP_LOAD)) begin
      value_store[item.coalition_index] <= item.value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= value_store[scan_mask];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      agent_count   <= gcp_pkg::COUNT_RESET;
      used_agents   <= '0;
      scan_position <= '0;
      issuing       <= 1'b0;
      pipe_valid    <= 1'b0;
      best_value    <= gcp_pkg::VALUE_FLOOR;
      best_subset   <= '0;
      found         <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_acc) begin
        agent_count <= cfg.agent_count;
      end

      // The register empties when its request leaves and no new pick replaces it.
      if (res_valid && result.ready && !res_load) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          // A solve with no agents has everything covered already and gives no result.
          if (item_acc && (item.op == gcp_pkg::OP_SOLVE) && (full != '0)) begin
            used_agents   <= '0;
            scan_position <= gcp_pkg::MASK_W'(1);
            issuing       <= 1'b1;
            pipe_valid    <= 1'b0;
            best_value    <= gcp_pkg::VALUE_FLOOR;
            best_subset   <= '0;
            found         <= 1'b0;
            state         <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // Stage one issues the memory read for the current position; stage two
          // compares the returned value against the running best.
          if (issuing) begin
            pipe_valid <= eligible;
            pipe_mask  <= scan_mask;
            if (scan_position == full) begin
              issuing <= 1'b0;
            end else begin
              scan_position <= scan_position + gcp_pkg::MASK_W'(1);
            end
          end else begin
            pipe_valid <= 1'b0;
            state      <= ST_DONE;
          end
          if (better) begin
            best_value  <= rd_data;
            best_subset <= pipe_mask;
            found       <= 1'b1;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_mask   <= found ? best_subset : '0;
            res_status <= found ? gcp_pkg::STATUS_OK : gcp_pkg::STATUS_NO_PICK;
            res_last   <= last_pick;
            if (found) begin
              used_agents <= used_after;
            end
            if (last_pick) begin
              state <= ST_IDLE;
            end else begin
              scan_position <= gcp_pkg::MASK_W'(1);
              issuing       <= 1'b1;
              pipe_valid    <= 1'b0;
              best_value    <= gcp_pkg::VALUE_FLOOR;
              best_subset   <= '0;
              found         <= 1'b0;
              state         <= ST_SCAN;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
